[design/mbpm_pkg.sv]
// shared types and constants for the barycentric point mapper
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mbpm_pkg;

   // configuration port
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_ACROSS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_DOWN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LEFT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_TOP      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_RIGHT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_BOTTOM   = 3'd5;

   // request kinds
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_MAP   = 1'b1;

   // datapath widths
   localparam int COORD_W = 16;
   localparam int TRI_W   = 9;
   localparam int MA_W    = 18;   // multiplier operand a, signed
   localparam int MB_W    = 35;   // multiplier operand b, signed
   localparam int PROD_W  = MA_W + MB_W;
   localparam int AREA_W  = 35;   // one cross product
   localparam int CMB_W   = 37;   // sums of cross products
   localparam int QUO_W   = 16;
   localparam int DVS_W   = 34;
   localparam int DVD_W   = DVS_W + QUO_W;

   typedef enum logic [4:0] {
      S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3,
      S_T1, S_T2, S_A1, S_A2, S_B1, S_B2, S_TEST,
      S_SC_MUL, S_SC_DIV, S_SC_WAIT,
      S_NX0, S_NX1, S_NX2, S_DX, S_DX_WAIT,
      S_NY0, S_NY1, S_NY2, S_DY, S_DY_WAIT,
      S_EMIT
   } mbpm_state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_T1, OP_T2, OP_A1, OP_A2, OP_B1, OP_B2, OP_SPAN,
      OP_NX0, OP_NX1, OP_NX2, OP_NY0, OP_NY1, OP_NY2
   } mbpm_op_type;

   typedef struct packed {
      logic        load;
      logic        rd_en;
      logic [1:0]  vsel;
      mbpm_op_type op;
      logic [1:0]  sc_idx;
      logic        div_start;
      logic        div_final;
      logic        sc_store;
      logic        store_x;
      logic        store_y;
      logic        latch_w;
      logic        scan_next;
      logic        out_load;
      logic        out_hit;
   } mbpm_cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
      logic div_done;
      logic out_full;
   } mbpm_status_type;

endpackage

[design/mesh_barycentric_point_mapper_core.sv]
// Mesh point mapper: a write word stores one camera grid point. A map word walks
// the mesh triangles in scan order, with three grid memory reads plus six passes
// through the shared multiplier and one containment test per triangle examined,
// then on a hit uses the 16-step divider, which forms four screen grid
// coordinates and the two interpolated results. One word is in flight at a time;
// the result sits in an output register, so the next word is taken while it waits.
// top level: depends on mbpm_pkg, mbpm_ctrl, mbpm_dp (which holds mbpm_div)
`timescale 1ns / 1ps

module mesh_barycentric_point_mapper_core import mbpm_pkg::*; #(
   parameter int MAX_CELLS = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_action,
   input  logic [7:0]            req_grid_index,
   input  logic [COORD_W-1:0]    req_cam_x,
   input  logic [COORD_W-1:0]    req_cam_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_W-1:0]    rsp_screen_x,
   output logic [COORD_W-1:0]    rsp_screen_y,
   output logic                  rsp_inside_res,
   output logic [TRI_W-1:0]      rsp_triangle_number,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   mbpm_cmd_type    cmd;
   mbpm_status_type status;

   mbpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   mbpm_dp #(
      .MAX_CELLS (MAX_CELLS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_action),
      .req_grid_index      (req_grid_index),
      .req_cam_x           (req_cam_x),
      .req_cam_y           (req_cam_y),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_screen_x        (rsp_screen_x),
      .rsp_screen_y        (rsp_screen_y),
      .rsp_inside_res      (rsp_inside_res),
      .rsp_triangle_number (rsp_triangle_number)
   );

endmodule

[design/mbpm_div.sv]
// restoring divider, one quotient bit per cycle, 16-bit quotient
// depends on mbpm_pkg; the caller guarantees the quotient fits in 16 bits
`timescale 1ns / 1ps

module mbpm_div import mbpm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dvd,
   input  logic [DVS_W-1:0] dvs,
   output logic             busy,
   output logic             done,
   output logic [QUO_W-1:0] quo
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [QUO_W-1:0] lo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   trial_sub;
   logic             fits;

   always_comb begin
      trial     = {rem_ff, lo_ff[QUO_W-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      fits      = (trial >= {1'b0, dvs_ff});
      rem_in    = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(QUO_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // remainder starts from the upper dividend bits; the caller must keep them below the divisor, unchecked here
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dvd[DVD_W-1:QUO_W];
         lo_ff  <= dvd[QUO_W-1:0];
         dvs_ff <= dvs;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         lo_ff  <= {lo_ff[QUO_W-2:0], fits};
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = lo_ff;

endmodule

[design/mbpm_dp.sv]
// datapath: config registers, grid point memory, scan counters, shared
// multiply-accumulate, divider and result register; depends on mbpm_pkg, mbpm_div
`timescale 1ns / 1ps

module mbpm_dp import mbpm_pkg::*; #(
   parameter int MAX_CELLS = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mbpm_cmd_type          cmd,
   output mbpm_status_type       status,
   input  logic                  req_action,
   input  logic [7:0]            req_grid_index,
   input  logic [COORD_W-1:0]    req_cam_x,
   input  logic [COORD_W-1:0]    req_cam_y,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_W-1:0]    rsp_screen_x,
   output logic [COORD_W-1:0]    rsp_screen_y,
   output logic                  rsp_inside_res,
   output logic [TRI_W-1:0]      rsp_triangle_number
);

   localparam int GRID_DEPTH = (MAX_CELLS + 1) * (MAX_CELLS + 1);
   localparam int AW = $clog2(GRID_DEPTH);
   localparam int CW = $clog2(MAX_CELLS + 1);

   // config
   logic [3:0]         cells_across_ff, cells_down_ff;
   logic [COORD_W-1:0] box_left_ff, box_top_ff, box_right_ff, box_bottom_ff;

   // grid memory
   logic [31:0]   grid_mem [GRID_DEPTH];
   logic [31:0]   mem_q_ff;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          rd_pend_ff;
   logic [1:0]    rd_sel_ff;

   logic [COORD_W-1:0] vx_ff [3];
   logic [COORD_W-1:0] vy_ff [3];
   logic [COORD_W-1:0] px_ff, py_ff;

   // scan position
   logic [CW-1:0]    ncx, ncy;
   logic [CW-1:0]    i_ff, j_ff;
   logic             half_ff;
   logic [TRI_W-1:0] tri_ff;
   logic [CW:0]      i_ext, j_ext, i_p1, j_p1, gi, gj, w;

   // arithmetic
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod, acc_ff, acc_in, acc_mag;
   logic signed [AREA_W-1:0] t_ff, a_ff, b_ff;
   logic signed [CMB_W-1:0]  t_e, a_e, b_e, c_e, na, nb, nc, nt;
   logic                     t_neg;
   logic [DVS_W-1:0]         wa_ff, wb_ff, wc_ff, tabs_ff, w_pick;
   logic [COORD_W-1:0]       sc_ff [4];
   logic [COORD_W-1:0]       sc_pick, sc_lo;
   logic                     sc_bit;
   logic signed [16:0]       span;
   logic [CW:0]              kval;
   logic [CW-1:0]            nsel;

   // divider
   logic               div_busy, div_done, div_neg_ff;
   logic [QUO_W-1:0]   div_quo;
   logic [DVD_W-1:0]   div_dvd;
   logic [DVS_W-1:0]   div_dvs;
   logic [QUO_W:0]     q_signed, sc_sum;

   // result
   logic               rsp_valid_ff;
   logic [COORD_W-1:0] res_x_ff, res_y_ff;
   logic [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic               rsp_inside_ff;
   logic [TRI_W-1:0]   rsp_tri_ff;

   function automatic logic [CW-1:0] clamp_cells(input logic [3:0] v);
      if (v == 4'd0) return CW'(1);
      else if (int'(v) > MAX_CELLS) return CW'(MAX_CELLS);
      else return CW'(v);
   endfunction

   function automatic logic signed [16:0] diff16(input logic [15:0] x, input logic [15:0] y);
      return $signed({1'b0, x}) - $signed({1'b0, y});
   endfunction

   function automatic logic signed [MA_W-1:0] ext_a(input logic signed [16:0] v);
      return $signed({{(MA_W-17){v[16]}}, v});
   endfunction

   function automatic logic signed [MB_W-1:0] ext_b(input logic signed [16:0] v);
      return $signed({{(MB_W-17){v[16]}}, v});
   endfunction

   function automatic logic signed [CMB_W-1:0] ext_c(input logic signed [AREA_W-1:0] v);
      return $signed({{(CMB_W-AREA_W){v[AREA_W-1]}}, v});
   endfunction

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         cells_across_ff <= 4'd4;
         cells_down_ff   <= 4'd4;
         box_left_ff     <= 16'd0;
         box_top_ff      <= 16'd0;
         box_right_ff    <= 16'd32768;
         box_bottom_ff   <= 16'd32768;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CELLS_ACROSS: cells_across_ff <= csr_wdata[3:0];
            CSR_CELLS_DOWN:   cells_down_ff   <= csr_wdata[3:0];
            CSR_BOX_LEFT:     box_left_ff     <= csr_wdata;
            CSR_BOX_TOP:      box_top_ff      <= csr_wdata;
            CSR_BOX_RIGHT:    box_right_ff    <= csr_wdata;
            CSR_BOX_BOTTOM:   box_bottom_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign ncx = clamp_cells(cells_across_ff);
   assign ncy = clamp_cells(cells_down_ff);

   // ---------------------------------------------------------------- memory
   assign i_ext = {1'b0, i_ff};
   assign j_ext = {1'b0, j_ff};
   assign i_p1  = i_ext + (CW+1)'(1);
   assign j_p1  = j_ext + (CW+1)'(1);
   assign w     = {1'b0, ncx} + (CW+1)'(1);

   // triangle corners: (ul, ur, ll) then (ur, lr, ll)
   always_comb begin
      case (cmd.vsel)
         2'd0: begin
            gi = half_ff ? i_p1 : i_ext;
            gj = j_ext;
         end
         2'd1: begin
            gi = i_p1;
            gj = half_ff ? j_p1 : j_ext;
         end
         default: begin
            gi = i_ext;
            gj = j_p1;
         end
      endcase
   end

   assign rd_addr = AW'(gi) + AW'(gj) * AW'(w);
   assign wr_addr = AW'(req_grid_index);

   always_ff @(posedge clock) begin
      if (cmd.load && (req_action == ACT_WRITE) && (int'(req_grid_index) < GRID_DEPTH)) begin
         grid_mem[wr_addr] <= {req_cam_y, req_cam_x};
      end
      if (cmd.rd_en) begin
         mem_q_ff <= grid_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_sel_ff <= cmd.vsel;
      if (rd_pend_ff) begin
         vx_ff[rd_sel_ff] <= mem_q_ff[15:0];
         vy_ff[rd_sel_ff] <= mem_q_ff[31:16];
      end
      if (cmd.load) begin
         px_ff <= req_cam_x;
         py_ff <= req_cam_y;
      end
   end

   // ---------------------------------------------------------------- scan
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         i_ff    <= '0;
         j_ff    <= '0;
         half_ff <= 1'b0;
         tri_ff  <= '0;
      end else if (cmd.scan_next) begin
         tri_ff <= tri_ff + TRI_W'(1);
         if (!half_ff) begin
            half_ff <= 1'b1;
         end else begin
            half_ff <= 1'b0;
            if (i_ff == ncx - CW'(1)) begin
               i_ff <= '0;
               j_ff <= j_ff + CW'(1);
            end else begin
               i_ff <= i_ff + CW'(1);
            end
         end
      end
   end

   // ---------------------------------------------------------------- mac
   assign span = cmd.sc_idx[1] ? diff16(box_bottom_ff, box_top_ff)
                               : diff16(box_right_ff, box_left_ff);
   assign kval = cmd.sc_idx[1] ? (cmd.sc_idx[0] ? j_p1 : j_ext)
                               : (cmd.sc_idx[0] ? i_p1 : i_ext);

   // which stored screen coordinate a corner uses: 0 is the low index, 1 the high
   always_comb begin
      case (cmd.op)
         OP_NX0:  sc_bit = half_ff;
         OP_NX1:  sc_bit = 1'b1;
         OP_NY1:  sc_bit = half_ff;
         OP_NY2:  sc_bit = 1'b1;
         default: sc_bit = 1'b0;
      endcase
      case (cmd.op)
         OP_NX0, OP_NX1, OP_NX2: sc_pick = sc_ff[{1'b0, sc_bit}];
         default:                sc_pick = sc_ff[{1'b1, sc_bit}];
      endcase
      case (cmd.op)
         OP_NX0, OP_NY0: w_pick = wa_ff;
         OP_NX1, OP_NY1: w_pick = wb_ff;
         default:        w_pick = wc_ff;
      endcase
   end

   always_comb begin
      case (cmd.op)
         OP_T1: begin
            mul_a = ext_a(diff16(vx_ff[0], vx_ff[1]));
            mul_b = ext_b(diff16(vy_ff[0], vy_ff[2]));
         end
         OP_T2: begin
            mul_a = ext_a(diff16(vy_ff[0], vy_ff[1]));
            mul_b = ext_b(diff16(vx_ff[0], vx_ff[2]));
         end
         OP_A1: begin
            mul_a = ext_a(diff16(px_ff, vx_ff[1]));
            mul_b = ext_b(diff16(py_ff, vy_ff[2]));
         end
         OP_A2: begin
            mul_a = ext_a(diff16(py_ff, vy_ff[1]));
            mul_b = ext_b(diff16(px_ff, vx_ff[2]));
         end
         OP_B1: begin
            mul_a = ext_a(diff16(vx_ff[0], px_ff));
            mul_b = ext_b(diff16(vy_ff[0], vy_ff[2]));
         end
         OP_B2: begin
            mul_a = ext_a(diff16(vy_ff[0], py_ff));
            mul_b = ext_b(diff16(vx_ff[0], vx_ff[2]));
         end
         OP_SPAN: begin
            mul_a = ext_a(span);
            mul_b = $signed({{(MB_W-CW-1){1'b0}}, kval});
         end
         OP_NX0, OP_NX1, OP_NX2, OP_NY0, OP_NY1, OP_NY2: begin
            mul_a = $signed({{(MA_W-COORD_W){1'b0}}, sc_pick});
            mul_b = $signed({{(MB_W-DVS_W){1'b0}}, w_pick});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      case (cmd.op)
         OP_T1, OP_A1, OP_B1, OP_SPAN, OP_NX0, OP_NY0: acc_in = prod;
         OP_T2, OP_A2, OP_B2:                         acc_in = acc_ff - prod;
         OP_NX1, OP_NX2, OP_NY1, OP_NY2:              acc_in = acc_ff + prod;
         default:                                     acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.op == OP_T2) t_ff <= acc_in[AREA_W-1:0];
      if (cmd.op == OP_A2) a_ff <= acc_in[AREA_W-1:0];
      if (cmd.op == OP_B2) b_ff <= acc_in[AREA_W-1:0];
   end

   // ---------------------------------------------------------------- test
   // areas folded to the sign of the total; inside when the total is non-zero and all are non-negative
   always_comb begin
      t_e   = ext_c(t_ff);
      a_e   = ext_c(a_ff);
      b_e   = ext_c(b_ff);
      c_e   = t_e - a_e - b_e;
      t_neg = t_ff[AREA_W-1];
      nt    = t_neg ? -t_e : t_e;
      na    = t_neg ? -a_e : a_e;
      nb    = t_neg ? -b_e : b_e;
      nc    = t_neg ? -c_e : c_e;
   end

   assign status.hit = (t_ff != '0) && !na[CMB_W-1] && !nb[CMB_W-1] && !nc[CMB_W-1];

   always_ff @(posedge clock) begin
      if (cmd.latch_w) begin
         wa_ff   <= na[DVS_W-1:0];
         wb_ff   <= nb[DVS_W-1:0];
         wc_ff   <= nc[DVS_W-1:0];
         tabs_ff <= nt[DVS_W-1:0];
      end
   end

   assign status.last = half_ff && (i_ff == ncx - CW'(1)) && (j_ff == ncy - CW'(1));

   // ---------------------------------------------------------------- divide
   assign acc_mag = acc_ff[PROD_W-1] ? -acc_ff : acc_ff;
   assign nsel    = cmd.sc_idx[1] ? ncy : ncx;
   assign div_dvd = acc_mag[DVD_W-1:0];
   assign div_dvs = cmd.div_final ? tabs_ff : {{(DVS_W-CW){1'b0}}, nsel};

   mbpm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .dvd   (div_dvd),
      .dvs   (div_dvs),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign status.div_done = div_done;

   always_ff @(posedge clock) begin
      if (cmd.div_start) div_neg_ff <= acc_ff[PROD_W-1];
   end

   // truncation toward zero: divide magnitudes, then put the sign back
   assign q_signed = div_neg_ff ? -{1'b0, div_quo} : {1'b0, div_quo};
   assign sc_lo    = cmd.sc_idx[1] ? box_top_ff : box_left_ff;
   assign sc_sum   = {1'b0, sc_lo} + q_signed;

   always_ff @(posedge clock) begin
      if (cmd.sc_store) sc_ff[cmd.sc_idx] <= sc_sum[COORD_W-1:0];
      if (cmd.store_x)  res_x_ff <= div_quo;
      if (cmd.store_y)  res_y_ff <= div_quo;
   end

   // ---------------------------------------------------------------- result
   assign status.out_full = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_inside_ff <= cmd.out_hit;
         rsp_x_ff      <= cmd.out_hit ? res_x_ff : '0;
         rsp_y_ff      <= cmd.out_hit ? res_y_ff : '0;
         rsp_tri_ff    <= cmd.out_hit ? tri_ff : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_screen_x        = rsp_x_ff;
   assign rsp_screen_y        = rsp_y_ff;
   assign rsp_inside_res      = rsp_inside_ff;
   assign rsp_triangle_number = rsp_tri_ff;

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider started while busy");

   a_out_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result register overwritten");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_inside_ff) |->
         (rsp_x_ff == '0) && (rsp_y_ff == '0) && (rsp_tri_ff == '0))
      else $error("outside result not zero");

endmodule

[design/mbpm_ctrl.sv]
// controller: sequences reads, multiplies, divisions and the result load
// depends on mbpm_pkg; drives the datapath through mbpm_cmd_type
`timescale 1ns / 1ps

module mbpm_ctrl import mbpm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_action,
   output logic            req_ready,
   input  mbpm_status_type status,
   output mbpm_cmd_type    cmd
);

   mbpm_state_type state_ff, state_in;
   logic [1:0]     sc_idx_ff, sc_idx_in;
   logic           hit_ff, hit_in;
   logic           accept;

   assign accept = req_valid && (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         sc_idx_ff <= 2'd0;
         hit_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sc_idx_ff <= sc_idx_in;
         hit_ff    <= hit_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sc_idx_in = sc_idx_ff;
      hit_in    = hit_ff;
      case (state_ff)
         S_IDLE:   if (accept && (req_action == ACT_MAP)) state_in = S_RD0;
         S_RD0:    state_in = S_RD1;
         S_RD1:    state_in = S_RD2;
         S_RD2:    state_in = S_RD3;
         S_RD3:    state_in = S_T1;
         S_T1:     state_in = S_T2;
         S_T2:     state_in = S_A1;
         S_A1:     state_in = S_A2;
         S_A2:     state_in = S_B1;
         S_B1:     state_in = S_B2;
         S_B2:     state_in = S_TEST;
         S_TEST: begin
            if (status.hit) begin
               hit_in    = 1'b1;
               sc_idx_in = 2'd0;
               state_in  = S_SC_MUL;
            end else if (status.last) begin
               hit_in   = 1'b0;
               state_in = S_EMIT;
            end else begin
               state_in = S_RD0;
            end
         end
         S_SC_MUL: state_in = S_SC_DIV;
         S_SC_DIV: state_in = S_SC_WAIT;
         S_SC_WAIT: begin
            if (status.div_done) begin
               if (sc_idx_ff == 2'd3) begin
                  state_in = S_NX0;
               end else begin
                  sc_idx_in = sc_idx_ff + 2'd1;
                  state_in  = S_SC_MUL;
               end
            end
         end
         S_NX0:     state_in = S_NX1;
         S_NX1:     state_in = S_NX2;
         S_NX2:     state_in = S_DX;
         S_DX:      state_in = S_DX_WAIT;
         S_DX_WAIT: if (status.div_done) state_in = S_NY0;
         S_NY0:     state_in = S_NY1;
         S_NY1:     state_in = S_NY2;
         S_NY2:     state_in = S_DY;
         S_DY:      state_in = S_DY_WAIT;
         S_DY_WAIT: if (status.div_done) state_in = S_EMIT;
         S_EMIT:    if (!status.out_full) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.op     = OP_NONE;
      cmd.sc_idx = sc_idx_ff;
      cmd.out_hit = hit_ff;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = accept;
         end
         S_RD0: begin
            cmd.rd_en = 1'b1;
            cmd.vsel  = 2'd0;
         end
         S_RD1: begin
            cmd.rd_en = 1'b1;
            cmd.vsel  = 2'd1;
         end
         S_RD2: begin
            cmd.rd_en = 1'b1;
            cmd.vsel  = 2'd2;
         end
         S_T1:     cmd.op = OP_T1;
         S_T2:     cmd.op = OP_T2;
         S_A1:     cmd.op = OP_A1;
         S_A2:     cmd.op = OP_A2;
         S_B1:     cmd.op = OP_B1;
         S_B2:     cmd.op = OP_B2;
         S_TEST: begin
            cmd.latch_w   = 1'b1;
            cmd.scan_next = !status.hit && !status.last;
         end
         S_SC_MUL:  cmd.op = OP_SPAN;
         S_SC_DIV:  cmd.div_start = 1'b1;
         S_SC_WAIT: cmd.sc_store = status.div_done;
         S_NX0:     cmd.op = OP_NX0;
         S_NX1:     cmd.op = OP_NX1;
         S_NX2:     cmd.op = OP_NX2;
         S_DX: begin
            cmd.div_start = 1'b1;
            cmd.div_final = 1'b1;
         end
         S_DX_WAIT: cmd.store_x = status.div_done;
         S_NY0:     cmd.op = OP_NY0;
         S_NY1:     cmd.op = OP_NY1;
         S_NY2:     cmd.op = OP_NY2;
         S_DY: begin
            cmd.div_start = 1'b1;
            cmd.div_final = 1'b1;
         end
         S_DY_WAIT: cmd.store_y = status.div_done;
         S_EMIT:    cmd.out_load = !status.out_full;
         default: ;
      endcase
   end

endmodule

[dv/tb.sv]
// testbench for mesh_barycentric_point_mapper_core: directed and random words,
// a scoreboard that predicts every mapped point. Depends on mbpm_pkg and the rtl.
`timescale 1ns / 1ps

module tb import mbpm_pkg::*; ;

   localparam int TABLE_DEPTH = 196;
   localparam int CELL_LIMIT  = 13;
   localparam int CYCLE_LIMIT = 20000000;
   localparam int WORD_TARGET = 1050;

   typedef struct {
      logic [15:0] sx;
      logic [15:0] sy;
      logic        hit;
      logic [8:0]  tri_num;
   } mapped_point_type;

   class mapper_scoreboard;
      logic [31:0]      grid_tbl [TABLE_DEPTH];
      logic [3:0]       across, down;
      logic [15:0]      bl, bt, br, bb;
      mapped_point_type expected_points [$];
      int               errors;

      function new();
         across = 4; down = 4; bl = 0; bt = 0; br = 16'd32768; bb = 16'd32768;
         errors = 0;
         foreach (grid_tbl[k]) grid_tbl[k] = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] v);
         case (idx)
            CSR_CELLS_ACROSS: across = v[3:0];
            CSR_CELLS_DOWN:   down = v[3:0];
            CSR_BOX_LEFT:     bl = v;
            CSR_BOX_TOP:      bt = v;
            CSR_BOX_RIGHT:    br = v;
            CSR_BOX_BOTTOM:   bb = v;
            default: ;
         endcase
      endfunction

      function int sgn(longint v);
         return (v > 0) - (v < 0);
      endfunction

      // inclusive: p and q on the same side of line ab, or one on it
      function bit same_side(longint px, longint py, longint qx, longint qy,
                             longint ax, longint ay, longint bx, longint by);
         longint c1, c2;
         c1 = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
         c2 = (bx - ax) * (qy - ay) - (by - ay) * (qx - ax);
         return sgn(c1) * sgn(c2) >= 0;
      endfunction

      function longint screen_coord(logic [15:0] lo, logic [15:0] hi, int k, int n);
         longint span;
         span = longint'(hi) - longint'(lo);
         return longint'(lo) + (span * k) / n;
      endfunction

      function mapped_point_type map_point(logic [15:0] x, logic [15:0] y);
         mapped_point_type r;
         int cx, cy, w;
         int gi [3];
         int gj [3];
         longint vx [3];
         longint vy [3];
         longint px, py, total, wt0, wt1, wt2, nx, ny, q;
         cx = (across == 0) ? 1 : (across > CELL_LIMIT) ? CELL_LIMIT : across;
         cy = (down == 0) ? 1 : (down > CELL_LIMIT) ? CELL_LIMIT : down;
         w = cx + 1;
         px = x; py = y;
         for (int j = 0; j < cy; j++) begin
            for (int i = 0; i < cx; i++) begin
               for (int half = 0; half < 2; half++) begin
                  if (half == 0) begin
                     gi = '{i, i + 1, i}; gj = '{j, j, j + 1};
                  end else begin
                     gi = '{i + 1, i + 1, i}; gj = '{j, j + 1, j + 1};
                  end
                  for (int k = 0; k < 3; k++) begin
                     vx[k] = grid_tbl[gi[k] + gj[k] * w][15:0];
                     vy[k] = grid_tbl[gi[k] + gj[k] * w][31:16];
                  end
                  total = (vx[0] - vx[1]) * (vy[0] - vy[2]) - (vy[0] - vy[1]) * (vx[0] - vx[2]);
                  if (total == 0) continue;
                  if (!same_side(px, py, vx[0], vy[0], vx[1], vy[1], vx[2], vy[2])) continue;
                  if (!same_side(px, py, vx[1], vy[1], vx[0], vy[0], vx[2], vy[2])) continue;
                  if (!same_side(px, py, vx[2], vy[2], vx[0], vy[0], vx[1], vy[1])) continue;
                  wt0 = (px - vx[1]) * (py - vy[2]) - (py - vy[1]) * (px - vx[2]);
                  wt1 = (vx[0] - px) * (vy[0] - vy[2]) - (vy[0] - py) * (vx[0] - vx[2]);
                  wt2 = total - wt0 - wt1;
                  if (total < 0) begin
                     total = -total; wt0 = -wt0; wt1 = -wt1; wt2 = -wt2;
                  end
                  nx = screen_coord(bl, br, gi[0], cx) * wt0 + screen_coord(bl, br, gi[1], cx) * wt1
                     + screen_coord(bl, br, gi[2], cx) * wt2;
                  ny = screen_coord(bt, bb, gj[0], cy) * wt0 + screen_coord(bt, bb, gj[1], cy) * wt1
                     + screen_coord(bt, bb, gj[2], cy) * wt2;
                  q = nx / total; r.sx = q[15:0];
                  q = ny / total; r.sy = q[15:0];
                  r.hit = 1'b1;
                  r.tri_num = 9'((j * cx + i) * 2 + half);
                  return r;
               end
            end
         end
         r.sx = '0; r.sy = '0; r.hit = 1'b0; r.tri_num = '0;
         return r;
      endfunction

      function void note_word(logic act, logic [7:0] idx, logic [15:0] x, logic [15:0] y);
         if (act == ACT_WRITE) begin
            if (idx < TABLE_DEPTH) grid_tbl[idx] = {y, x};
         end else begin
            expected_points.push_back(map_point(x, y));
         end
      endfunction

      function void check_word(logic [15:0] sx, logic [15:0] sy, logic hit,
                               logic [8:0] tri_num);
         mapped_point_type e;
         if (expected_points.size() == 0) begin
            $display("%0t: result word with none expected", $time);
            errors++;
            return;
         end
         e = expected_points.pop_front();
         if (sx !== e.sx) begin
            $display("%0t: screen_x expected %0d actual %0d", $time, e.sx, sx);
            errors++;
         end
         if (sy !== e.sy) begin
            $display("%0t: screen_y expected %0d actual %0d", $time, e.sy, sy);
            errors++;
         end
         if (hit !== e.hit) begin
            $display("%0t: inside_res expected %0d actual %0d", $time, e.hit, hit);
            errors++;
         end
         if (tri_num !== e.tri_num) begin
            $display("%0t: triangle_number expected %0d actual %0d", $time, e.tri_num, tri_num);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid, req_ready, req_action;
   logic [7:0]            req_grid_index;
   logic [COORD_W-1:0]    req_cam_x, req_cam_y;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [COORD_W-1:0]    rsp_screen_x, rsp_screen_y;
   logic                  rsp_inside_res;
   logic [TRI_W-1:0]      rsp_triangle_number;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mapper_scoreboard sb = new();
   int   words_sent = 0;
   int   cycles = 0;
   int   stall_left = 0;
   bit   no_idle = 0;
   logic [15:0] pts_x [TABLE_DEPTH];
   logic [15:0] pts_y [TABLE_DEPTH];
   int   lay_cx, lay_cy, lo_x, hi_x, lo_y, hi_y, pitch;

   mesh_barycentric_point_mapper_core u_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_word(req_action, req_grid_index, req_cam_x, req_cam_y);
         if (rsp_valid && rsp_ready)
            sb.check_word(rsp_screen_x, rsp_screen_y, rsp_inside_res, rsp_triangle_number);
      end
   end

   function int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // receiver stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         stall_left <= idle_len();
         rsp_ready <= 1'b1;
      end
   end

   function logic [15:0] clamp16(int v);
      return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : 16'(v);
   endfunction

   task automatic send(logic act, logic [7:0] idx, logic [15:0] x, logic [15:0] y);
      int  gap;
      bit  ok;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_grid_index <= idx;
      req_cam_x <= x;
      req_cam_y <= y;
      do begin
         @(negedge clock);
         ok = req_ready;
         @(posedge clock);
      end while (!ok);
      if (act == ACT_WRITE && idx < TABLE_DEPTH) begin
         pts_x[idx] = x;
         pts_y[idx] = y;
      end
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_points.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_config(logic [15:0] vals [6]);
      for (int k = 0; k < 6; k++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(k);
         csr_wdata <= vals[k];
         @(posedge clock);
         sb.set_reg(CSR_IDX_W'(k), vals[k]);
      end
      csr_we <= 1'b0;
   endtask

   // regular grid with jitter, sometimes mirrored
   task automatic load_grid(int cx, int cy);
      int sy, jit, x0, y0, gx, gy;
      bit flip;
      pitch = $urandom_range(32, 64000 / (cx + 1));
      sy = $urandom_range(32, 64000 / (cy + 1));
      jit = pitch / 4;
      x0 = $urandom_range(jit, 65535 - cx * pitch - jit);
      y0 = $urandom_range(sy / 4, 65535 - cy * sy - sy / 4);
      flip = ($urandom_range(0, 4) == 0);
      lay_cx = cx; lay_cy = cy;
      lo_x = x0 - pitch / 2; hi_x = x0 + cx * pitch + pitch / 2;
      lo_y = y0 - sy / 2; hi_y = y0 + cy * sy + sy / 2;
      for (int j = 0; j <= cy; j++) begin
         for (int i = 0; i <= cx; i++) begin
            gx = x0 + (flip ? cx - i : i) * pitch + $urandom_range(0, 2 * jit) - jit;
            gy = y0 + j * sy + $urandom_range(0, sy / 2) - sy / 4;
            send(ACT_WRITE, 8'(j * (cx + 1) + i), clamp16(gx), clamp16(gy));
         end
      end
   endtask

   task automatic random_word();
      int r, k;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, lay_cy) * (lay_cx + 1) + $urandom_range(0, lay_cx);
      if (r < 3) begin
         send(ACT_WRITE, 8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom));
      end else if (r < 15) begin
         send(ACT_WRITE, 8'(k), clamp16(pts_x[k] + $urandom_range(0, 16) - 8),
              clamp16(pts_y[k] + $urandom_range(0, 16) - 8));
      end else if (r < 25) begin
         send(ACT_MAP, 8'($urandom), 16'($urandom), 16'($urandom));
      end else if (r < 35) begin
         send(ACT_MAP, 8'($urandom), pts_x[k], pts_y[k]);
      end else begin
         send(ACT_MAP, 8'($urandom), clamp16($urandom_range(0, hi_x - lo_x) + lo_x),
              clamp16($urandom_range(0, hi_y - lo_y) + lo_y));
      end
   endtask

   initial begin
      logic [15:0] cfg [6];
      int cx, cy, n, phase;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_WRITE;
      req_grid_index <= '0;
      req_cam_x <= '0;
      req_cam_y <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // every table entry zero: all triangles degenerate
      for (int k = 0; k < TABLE_DEPTH; k++) send(ACT_WRITE, 8'(k), 16'd0, 16'd0);
      send(ACT_MAP, 8'd0, 16'd0, 16'd0);
      send(ACT_MAP, 8'hFF, 16'hFFFF, 16'hFFFF);
      // out of range write indexes are dropped
      send(ACT_WRITE, 8'd196, 16'hFFFF, 16'hFFFF);
      send(ACT_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF);
      send(ACT_MAP, 8'd0, 16'hFFFF, 16'hFFFF);
      drain();

      phase = 0;
      while (words_sent < WORD_TARGET) begin
         case (phase)
            0: cfg = '{16'd4, 16'd4, 16'd0, 16'd0, 16'd32768, 16'd32768};
            1: cfg = '{16'd13, 16'd13, 16'd0, 16'd0, 16'd32768, 16'd32768};
            2: cfg = '{16'd1, 16'd1, 16'd32768, 16'd32768, 16'd0, 16'd0};
            3: cfg = '{16'd0, 16'd15, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF};
            4: cfg = '{16'd15, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0};
            default: begin
               cfg[0] = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 13))
                                                    : 16'($urandom_range(1, 6));
               cfg[1] = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 13))
                                                    : 16'($urandom_range(1, 6));
               cfg[2] = 16'($urandom_range(0, 16384));
               cfg[3] = 16'($urandom_range(0, 16384));
               cfg[4] = 16'($urandom_range(16384, 32768));
               cfg[5] = 16'($urandom_range(16384, 32768));
            end
         endcase
         if (phase > 0) set_config(cfg);
         no_idle = (phase % 4 == 2);
         cx = (cfg[0][3:0] == 0) ? 1 : (cfg[0][3:0] > CELL_LIMIT) ? CELL_LIMIT : cfg[0][3:0];
         cy = (cfg[1][3:0] == 0) ? 1 : (cfg[1][3:0] > CELL_LIMIT) ? CELL_LIMIT : cfg[1][3:0];
         load_grid(cx, cy);
         if (phase == 0) begin
            // exact grid points and cell centers
            for (int k = 0; k < 25; k += 3) send(ACT_MAP, 8'd0, pts_x[k], pts_y[k]);
            send(ACT_MAP, 8'd0, 16'((pts_x[0] + pts_x[6]) / 2), 16'((pts_y[0] + pts_y[6]) / 2));
            send(ACT_MAP, 8'd0, 16'((pts_x[18] + pts_x[24]) / 2),
                 16'((pts_y[18] + pts_y[24]) / 2));
         end
         n = (cx * cy > 60) ? 25 : 90;
         repeat (n) random_word();
         // sender holds off until every result is back
         drain();
         phase++;
      end

      no_idle = 0;
      drain();
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
